// ===== design/lcs_pkg.sv =====
// Shared types and codes for the LED chain serializer.
package lcs_pkg;

    localparam int PIXEL_BITS = 24;
    localparam int INDEX_BITS = 10;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [1:0] CFG_BIT_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_ZERO_HIGH   = 2'd1;
    localparam logic [1:0] CFG_ONE_HIGH    = 2'd2;
    localparam logic [1:0] CFG_RESET_SLOTS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DATA = 3'b010,
        ST_TAIL = 3'b100
    } frame_state_t;

    typedef struct packed {
        logic [15:0] bit_period;
        logic [15:0] zero_high;
        logic [15:0] one_high;
        logic [9:0]  reset_slots;
    } cfg_t;

    typedef struct packed {
        logic                  wr_en;
        logic [INDEX_BITS-1:0] wr_addr;
        logic [PIXEL_BITS-1:0] wr_data;
        logic                  clear;
    } store_ctl_t;

    typedef struct packed {
        logic level;
        logic sending;
        logic done;
    } result_t;

endpackage

// ===== design/lcs_pixel_store.sv =====
// Pixel memory with clear sweep, registered read port and a copy of pixel 0.
module lcs_pixel_store #(
    parameter int PIXEL_COUNT = 8,
    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcs_pkg::store_ctl_t           ctl,
    input  logic [AW-1:0]                 rd_addr,
    output logic [lcs_pkg::PIXEL_BITS-1:0] rd_data,
    output logic [lcs_pkg::PIXEL_BITS-1:0] pix0,
    output logic                          sweeping
);

    localparam logic [AW-1:0] LAST = AW'(PIXEL_COUNT - 1);

    logic [lcs_pkg::PIXEL_BITS-1:0] mem [PIXEL_COUNT];
    logic [lcs_pkg::PIXEL_BITS-1:0] mem_q_reg;
    logic [lcs_pkg::PIXEL_BITS-1:0] pix0_reg;
    logic                           sweep_reg;
    logic [AW-1:0]                  sweep_cnt_reg;

    logic                           we;
    logic [AW-1:0]                  wa;
    logic [lcs_pkg::PIXEL_BITS-1:0] wd;

    always_comb
    begin
        if (sweep_reg)
        begin
            we = 1'b1;
            wa = sweep_cnt_reg;
            wd = '0;
        end
        else
        begin
            we = ctl.wr_en;
            wa = ctl.wr_addr[AW-1:0];
            wd = ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            pix0_reg      <= '0;
        end
        else
        begin
            if (ctl.clear)
            begin
                sweep_reg     <= 1'b1;
                sweep_cnt_reg <= '0;
                pix0_reg      <= '0;
            end
            else if (sweep_reg)
            begin
                if (sweep_cnt_reg == LAST)
                begin
                    sweep_reg <= 1'b0;
                end
                else
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                end
            end
            else if (ctl.wr_en && (ctl.wr_addr == '0))
            begin
                pix0_reg <= ctl.wr_data;
            end
        end
    end

    assign rd_data  = mem_q_reg;
    assign pix0     = pix0_reg;
    assign sweeping = sweep_reg;

endmodule

// ===== design/lcs_line_timer.sv =====
// Frame sequencer: slot and tick counters, bit shifter and line level.
module lcs_line_timer #(
    parameter int PIXEL_COUNT = 8,
    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [1:0]                     action,
    input  lcs_pkg::cfg_t                  cfg,
    input  logic [lcs_pkg::PIXEL_BITS-1:0] pix0,
    input  logic [lcs_pkg::PIXEL_BITS-1:0] next_pixel,
    output logic [AW-1:0]                  fetch_addr,
    output logic                           busy,
    output lcs_pkg::result_t               result
);

    localparam logic [AW-1:0] LAST = AW'(PIXEL_COUNT - 1);
    localparam logic [AW-1:0] FIRST_FETCH = (PIXEL_COUNT > 1) ? AW'(1) : '0;
    localparam logic [4:0] LAST_BIT = 5'(lcs_pkg::PIXEL_BITS - 1);

    lcs_pkg::frame_state_t          state_reg;
    logic [15:0]                    tick_reg;
    logic [4:0]                     bit_cnt_reg;
    logic [AW-1:0]                  pix_cnt_reg;
    logic [AW-1:0]                  fetch_reg;
    logic [9:0]                     tail_cnt_reg;
    logic [lcs_pkg::PIXEL_BITS-1:0] word_reg;

    logic [15:0] period_eff;
    logic [16:0] tick_inc;
    logic [10:0] tail_inc;
    logic        slot_end;
    logic        tail_end;
    logic [15:0] high_now;
    logic [15:0] high_start;
    logic        level_now;
    logic        do_start;
    logic        do_tick;
    logic        frame_end;

    always_comb
    begin
        period_eff = (cfg.bit_period == '0) ? 16'd1 : cfg.bit_period;
        tick_inc   = {1'b0, tick_reg} + 17'd1;
        slot_end   = tick_inc >= {1'b0, period_eff};
        tail_inc   = {1'b0, tail_cnt_reg} + 11'd1;
        tail_end   = tail_inc >= {1'b0, cfg.reset_slots};
        high_now   = word_reg[lcs_pkg::PIXEL_BITS-1] ? cfg.one_high : cfg.zero_high;
        high_start = pix0[lcs_pkg::PIXEL_BITS-1] ? cfg.one_high : cfg.zero_high;
        level_now  = (state_reg == lcs_pkg::ST_DATA) && (tick_reg < high_now);
        do_start   = step && (action == lcs_pkg::ACT_START) && (state_reg == lcs_pkg::ST_IDLE);
        do_tick    = step && (action == lcs_pkg::ACT_TICK) && (state_reg != lcs_pkg::ST_IDLE);

        frame_end = 1'b0;
        if (do_tick && slot_end)
        begin
            if (state_reg == lcs_pkg::ST_DATA)
            begin
                frame_end = (bit_cnt_reg == LAST_BIT) && (pix_cnt_reg == LAST)
                            && (cfg.reset_slots == '0);
            end
            else
            begin
                frame_end = tail_end;
            end
        end

        if (do_start)
        begin
            result.level   = (high_start != '0);
            result.sending = 1'b1;
        end
        else
        begin
            result.level   = level_now;
            result.sending = (state_reg != lcs_pkg::ST_IDLE) && !frame_end;
        end
        result.done = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lcs_pkg::ST_IDLE;
            tick_reg     <= '0;
            bit_cnt_reg  <= '0;
            pix_cnt_reg  <= '0;
            fetch_reg    <= '0;
            tail_cnt_reg <= '0;
        end
        else if (do_start)
        begin
            state_reg   <= lcs_pkg::ST_DATA;
            tick_reg    <= '0;
            bit_cnt_reg <= '0;
            pix_cnt_reg <= '0;
            fetch_reg   <= FIRST_FETCH;
        end
        else if (do_tick)
        begin
            if (!slot_end)
            begin
                tick_reg <= tick_inc[15:0];
            end
            else
            begin
                tick_reg <= '0;
                if (frame_end)
                begin
                    state_reg <= lcs_pkg::ST_IDLE;
                end
                else if (state_reg == lcs_pkg::ST_DATA)
                begin
                    if (bit_cnt_reg == LAST_BIT)
                    begin
                        bit_cnt_reg <= '0;
                        if (pix_cnt_reg == LAST)
                        begin
                            state_reg    <= lcs_pkg::ST_TAIL;
                            tail_cnt_reg <= '0;
                        end
                        else
                        begin
                            pix_cnt_reg <= pix_cnt_reg + 1'b1;
                            if (fetch_reg != LAST)
                            begin
                                fetch_reg <= fetch_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    tail_cnt_reg <= tail_inc[9:0];
                end
            end
        end
    end

    // MSB of word_reg is the bit on the line
    always_ff @(posedge clk)
    begin
        if (do_start)
        begin
            word_reg <= pix0;
        end
        else if (do_tick && slot_end && (state_reg == lcs_pkg::ST_DATA))
        begin
            if (bit_cnt_reg == LAST_BIT)
            begin
                word_reg <= next_pixel;
            end
            else
            begin
                word_reg <= {word_reg[lcs_pkg::PIXEL_BITS-2:0], 1'b0};
            end
        end
    end

    assign fetch_addr = fetch_reg;
    assign busy       = (state_reg != lcs_pkg::ST_IDLE);

endmodule

// ===== design/rgb_led_chain_serializer_unit.sv =====
// Top level of the one-wire RGB LED chain serializer.
// One command is taken per clock (write pixel, clear, start frame, tick) when no sweep
// runs and the status output is free, and each gives one status transfer: line level,
// sending flag and frame_done on tlast. Commands pass an input register and a result
// register, so the sustained rate is one per cycle when the output does not stall. A
// clear while idle, and reset, start a sweep of the pixel memory during which no
// command is taken; configuration writes are taken at any time. Pixels are sent green,
// red, blue, MSB first, followed by reset_slots low slots.
module rgb_led_chain_serializer_unit #(
    parameter int PIXEL_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // pixel_index[9:0], red, green, blue, zero pad
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // line_level, sending, zero pad
    output logic        m_axis_tlast,  // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    lcs_pkg::cfg_t      cfg_reg;
    logic               s1_valid_reg;
    logic [1:0]         s1_action_reg;
    logic [9:0]         s1_index_reg;
    logic [7:0]         s1_red_reg;
    logic [7:0]         s1_green_reg;
    logic [7:0]         s1_blue_reg;
    logic               out_valid_reg;
    lcs_pkg::result_t   res_reg;

    logic                           s1_move;
    logic                           res_free;
    logic                           sweeping;
    logic                           busy;
    lcs_pkg::store_ctl_t            store_ctl;
    lcs_pkg::result_t               result;
    logic [AW-1:0]                  fetch_addr;
    logic [lcs_pkg::PIXEL_BITS-1:0] next_pixel;
    logic [lcs_pkg::PIXEL_BITS-1:0] pix0;

    assign cfg_ready     = 1'b1;
    assign res_free      = !out_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && res_free && !sweeping;
    assign s_axis_tready = !sweeping && (!s1_valid_reg || s1_move);

    always_comb
    begin
        store_ctl.wr_en   = s1_move && !busy && (s1_action_reg == lcs_pkg::ACT_WRITE)
                            && ({1'b0, s1_index_reg} < 11'(PIXEL_COUNT));
        store_ctl.wr_addr = s1_index_reg;
        store_ctl.wr_data = {s1_green_reg, s1_red_reg, s1_blue_reg};
        store_ctl.clear   = s1_move && !busy && (s1_action_reg == lcs_pkg::ACT_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period  <= 16'd100;
            cfg_reg.zero_high   <= 16'd32;
            cfg_reg.one_high    <= 16'd64;
            cfg_reg.reset_slots <= 10'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcs_pkg::CFG_BIT_PERIOD:  cfg_reg.bit_period  <= cfg_data;
                lcs_pkg::CFG_ZERO_HIGH:   cfg_reg.zero_high   <= cfg_data;
                lcs_pkg::CFG_ONE_HIGH:    cfg_reg.one_high    <= cfg_data;
                lcs_pkg::CFG_RESET_SLOTS: cfg_reg.reset_slots <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_action_reg <= s_axis_tuser;
            s1_index_reg  <= s_axis_tdata[9:0];
            s1_red_reg    <= s_axis_tdata[17:10];
            s1_green_reg  <= s_axis_tdata[25:18];
            s1_blue_reg   <= s_axis_tdata[33:26];
        end
        if (s1_move)
        begin
            res_reg <= result;
        end
    end

    lcs_pixel_store #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (store_ctl),
        .rd_addr  (fetch_addr),
        .rd_data  (next_pixel),
        .pix0     (pix0),
        .sweeping (sweeping)
    );

    lcs_line_timer #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_move),
        .action     (s1_action_reg),
        .cfg        (cfg_reg),
        .pix0       (pix0),
        .next_pixel (next_pixel),
        .fetch_addr (fetch_addr),
        .busy       (busy),
        .result     (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg.sending, res_reg.level};
    assign m_axis_tlast  = res_reg.done;

    a_done_ends_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done |-> !res_reg.sending)
        else $error("frame_done reported while still sending");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !busy && (s1_action_reg == lcs_pkg::ACT_START) |=> busy)
        else $error("start command did not begin a frame");

    a_no_store_access_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !store_ctl.wr_en && !store_ctl.clear && !sweeping)
        else $error("pixel store changed during a frame");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_action_reg))
        else $error("pending command lost while stalled");

endmodule

// ===== sim/lcs_status_checker.sv =====
`timescale 1ns / 1ps
// Status checker for the LED chain serializer: predicts every status transfer and compares it.
module lcs_status_checker #(
    parameter int PIXEL_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // pixel_index[9:0], red, green, blue, zero pad
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,  // line_level, sending, zero pad
    input  logic        m_axis_tlast,  // frame_done
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          outstanding
);

    localparam int DATA_SLOTS = PIXEL_COUNT * lcs_pkg::PIXEL_BITS;

    logic [lcs_pkg::PIXEL_BITS-1:0] pixels [PIXEL_COUNT];
    logic                           sending;
    int                             slot;
    int                             tick;
    lcs_pkg::cfg_t                  cfg;
    lcs_pkg::result_t               status_due [$];
    lcs_pkg::result_t               want;
    int                             err_cnt = 0;
    int                             n_results = 0;

    task automatic report(string msg);
        if (err_cnt < 40)
            $display("ERROR at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    // line level at the current slot position
    function automatic logic slot_level();
        logic [lcs_pkg::PIXEL_BITS-1:0] word;
        int                             high;
        if (!sending || slot >= DATA_SLOTS)
            return 1'b0;
        word = pixels[slot / lcs_pkg::PIXEL_BITS];
        high = word[lcs_pkg::PIXEL_BITS - 1 - slot % lcs_pkg::PIXEL_BITS]
               ? int'(cfg.one_high) : int'(cfg.zero_high);
        return (tick < high);
    endfunction

    function automatic lcs_pkg::result_t step_line(logic [1:0] act, logic [9:0] idx,
                                                   logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
        lcs_pkg::result_t res;
        int               period;
        res = '0;
        period = (cfg.bit_period == 16'd0) ? 1 : int'(cfg.bit_period);
        if (act == lcs_pkg::ACT_TICK) begin
            res.level = slot_level();
            if (sending) begin
                tick++;
                if (tick >= period) begin
                    tick = 0;
                    slot++;
                    if (slot >= DATA_SLOTS + int'(cfg.reset_slots)) begin
                        sending = 1'b0;
                        slot = 0;
                        res.done = 1'b1;
                    end
                end
            end
        end else begin
            if (!sending) begin
                case (act)
                    lcs_pkg::ACT_WRITE: if (idx < PIXEL_COUNT) pixels[idx] = {g, r, b};
                    lcs_pkg::ACT_CLEAR: for (int i = 0; i < PIXEL_COUNT; i++) pixels[i] = '0;
                    default:
                    begin
                        sending = 1'b1;
                        slot = 0;
                        tick = 0;
                    end
                endcase
            end
            res.level = slot_level();
        end
        res.sending = sending;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < PIXEL_COUNT; i++) pixels[i] = '0;
            sending = 1'b0;
            slot = 0;
            tick = 0;
            cfg.bit_period = 16'd100;
            cfg.zero_high = 16'd32;
            cfg.one_high = 16'd64;
            cfg.reset_slots = 10'd100;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lcs_pkg::CFG_BIT_PERIOD:  cfg.bit_period = cfg_data;
                    lcs_pkg::CFG_ZERO_HIGH:   cfg.zero_high = cfg_data;
                    lcs_pkg::CFG_ONE_HIGH:    cfg.one_high = cfg_data;
                    lcs_pkg::CFG_RESET_SLOTS: cfg.reset_slots = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                status_due.push_back(step_line(s_axis_tuser, s_axis_tdata[9:0],
                                               s_axis_tdata[17:10], s_axis_tdata[25:18],
                                               s_axis_tdata[33:26]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_due.size() == 0) begin
                    report($sformatf("status transfer %0d with no command pending", n_results));
                end else begin
                    want = status_due.pop_front();
                    if (m_axis_tdata[0] !== want.level)
                        report($sformatf("status %0d line_level %b, expected %b",
                                         n_results, m_axis_tdata[0], want.level));
                    if (m_axis_tdata[1] !== want.sending)
                        report($sformatf("status %0d sending %b, expected %b",
                                         n_results, m_axis_tdata[1], want.sending));
                    if (m_axis_tlast !== want.done)
                        report($sformatf("status %0d frame_done %b, expected %b",
                                         n_results, m_axis_tlast, want.done));
                end
                n_results++;
            end
        end
        errors <= err_cnt;
        outstanding <= status_due.size();
    end

endmodule

// ===== sim/rgb_led_chain_serializer_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the LED chain serializer: stimulus, register settings and verdict.
module rgb_led_chain_serializer_unit_tb;

    localparam int PIXEL_COUNT = 8;
    localparam int DATA_SLOTS = PIXEL_COUNT * lcs_pkg::PIXEL_BITS;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int errors;
    int outstanding;
    int tx_gap_max = 6;
    int rx_stall_max = 6;
    int n_cmds = 0;
    int n_frames = 0;
    int n_settings = 0;

    rgb_led_chain_serializer_unit #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lcs_status_checker #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) status_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // status receiver with random stalls
    initial begin
        int w;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            w = $urandom_range(0, rx_stall_max);
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_cmd(logic [1:0] act, logic [9:0] idx,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {6'd0, b, g, r, idx};
        do @(posedge clk); while (!s_axis_tready);
        n_cmds++;
    endtask

    task automatic send_tick();
        send_cmd(lcs_pkg::ACT_TICK, 10'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_config(logic [15:0] period, logic [15:0] zero_high,
                                logic [15:0] one_high, logic [15:0] tail_word);
        logic [15:0] vals [4];
        logic [1:0]  regs [4];
        vals = '{period, zero_high, one_high, tail_word};
        regs = '{lcs_pkg::CFG_BIT_PERIOD, lcs_pkg::CFG_ZERO_HIGH, lcs_pkg::CFG_ONE_HIGH,
                 lcs_pkg::CFG_RESET_SLOTS};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // pixel writes, clears and idle ticks between frames
    task automatic load_pixels();
        int n;
        n = $urandom_range(4, 14);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: send_cmd(lcs_pkg::ACT_WRITE, 10'($urandom_range(PIXEL_COUNT, 1023)),
                            8'($urandom), 8'($urandom), 8'($urandom));
                1: send_cmd(lcs_pkg::ACT_CLEAR, 10'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom));
                2: send_tick();
                default: send_cmd(lcs_pkg::ACT_WRITE,
                                  10'($urandom_range(0, PIXEL_COUNT - 1)),
                                  8'($urandom), 8'($urandom), 8'($urandom));
            endcase
        end
    endtask

    // start, then tick through the frame with ignored commands mixed in
    task automatic run_frame(int period, int tail, int tick_cap);
        int         len;
        int         ticks;
        int         hold_at;
        logic [1:0] act;
        len = (DATA_SLOTS + tail) * ((period == 0) ? 1 : period);
        if (len > tick_cap)
            len = tick_cap;
        hold_at = $urandom_range(1, len);
        send_cmd(lcs_pkg::ACT_START, 10'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
        n_frames++;
        ticks = 0;
        while (ticks < len) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0: act = lcs_pkg::ACT_WRITE;
                    1: act = lcs_pkg::ACT_CLEAR;
                    default: act = lcs_pkg::ACT_START;
                endcase
                send_cmd(act, 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_tick();
                ticks++;
                if (ticks == hold_at)
                    wait_results();
            end
        end
    endtask

    task automatic run_phase(int period, int zero_high, int one_high, int tail_word,
                             int frames, int tick_cap);
        wait_results();
        write_config(16'(period), 16'(zero_high), 16'(one_high), 16'(tail_word));
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        repeat (frames) begin
            load_pixels();
            run_frame(period, tail_word % 1024, tick_cap);
        end
        load_pixels();
    endtask

    initial begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = lcs_pkg::ACT_WRITE;
        cfg_valid = 1'b0;
        cfg_index = lcs_pkg::CFG_BIT_PERIOD;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default registers, idle behavior
        send_cmd(lcs_pkg::ACT_TICK, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(lcs_pkg::ACT_WRITE, 10'd0, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(lcs_pkg::ACT_WRITE, 10'd7, 8'h00, 8'h00, 8'h00);
        send_cmd(lcs_pkg::ACT_WRITE, 10'd8, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(lcs_pkg::ACT_WRITE, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(lcs_pkg::ACT_WRITE, 10'd5, 8'hA5, 8'h5A, 8'h3C);
        send_cmd(lcs_pkg::ACT_CLEAR, 10'd0, 8'h00, 8'h00, 8'h00);
        send_cmd(lcs_pkg::ACT_TICK, 10'd0, 8'h00, 8'h00, 8'h00);
        send_cmd(lcs_pkg::ACT_WRITE, 10'd0, 8'h80, 8'h01, 8'hFF);
        send_cmd(lcs_pkg::ACT_WRITE, 10'd7, 8'hFF, 8'h00, 8'h81);
        send_cmd(lcs_pkg::ACT_WRITE, 10'd3, 8'h55, 8'hAA, 8'h0F);

        // zero period, high time beyond the slot, no trailing low slots
        wait_results();
        write_config(16'd0, 16'd0, 16'hFFFF, 16'hFC00);
        send_cmd(lcs_pkg::ACT_START, 10'd0, 8'h00, 8'h00, 8'h00);
        send_tick();
        send_cmd(lcs_pkg::ACT_WRITE, 10'd1, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(lcs_pkg::ACT_CLEAR, 10'd0, 8'h00, 8'h00, 8'h00);
        send_cmd(lcs_pkg::ACT_START, 10'd0, 8'h00, 8'h00, 8'h00);
        n_frames++;
        repeat (DATA_SLOTS - 1) send_tick();
        send_tick();

        // random phases
        run_phase(1, 0, 1, 3, 1, 1 << 30);
        run_phase(1, 1, 2, 0, 1, 1 << 30);
        run_phase(2, 65535, 0, 1, 1, 1 << 30);
        // longest period and widest tail: the frame is left running at the end
        run_phase(65535, $urandom_range(1, 300), $urandom_range(0, 65535),
                  65535, 1, 150);

        wait_results();
        repeat (20) @(posedge clk);
        $display("Covered %0d commands, %0d frame starts, %0d register settings.",
                 n_cmds, n_frames, n_settings);
        $display("Both channels ran with random gaps, gap-free stretches and mid-frame drains.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
